[design/priority_round_robin_task_scheduler_macros.svh]
// Assertion helpers for the scheduler RTL.
`ifndef PRIORITY_ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH
`define PRIORITY_ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define PRRS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define PRRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/prrs_pkg.sv]
`default_nettype none
package prrs_pkg;

  localparam int SLOTS_DEF = 16;

  typedef enum logic [2:0] {
    OP_INSERT   = 3'd0,
    OP_REMOVE   = 3'd1,
    OP_DELAY    = 3'd2,
    OP_SCHEDULE = 3'd3,
    OP_TICK     = 3'd4,
    OP_FIND     = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  task_id;
    logic [15:0] priority_req;
    logic [31:0] delay_ticks;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  next_task;
    logic        next_is_idle;
    logic        switch_request;
    logic [31:0] next_slices;
    logic [15:0] found_priority;
  } out_item_t;

  // One row of the task table.
  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] prio;
    logic [31:0] wake;
    logic [31:0] slices;
  } entry_t;

endpackage
`default_nettype wire

[design/prrs_mem.sv]
`default_nettype none
module prrs_mem
  import prrs_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF,
  localparam int AW = $clog2(SLOTS)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire entry_t        wdata,
  input  wire logic [AW-1:0] raddr,
  output entry_t             rdata
);

  entry_t mem [SLOTS];
  entry_t rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r <= mem[raddr];
  end

  assign rdata = rd_r;

endmodule
`default_nettype wire

[design/priority_round_robin_task_scheduler.sv]
// Priority round-robin task scheduler.
// Input channel (in_valid/in_ready/in_data) takes one operation beat:
// insert, remove, delay, schedule, tick or find. Result channel
// (out_valid/out_ready/out_data) returns exactly one beat per operation with
// status, the current selection, switch request, slice count and found
// priority. cfg_wr_en/cfg_wr_data write system_ready at once, no wait.
// The task table sits in one synchronous single-read-port memory; each
// table visit issues a read and then evaluates the row. Insert searches
// then shifts rows up, remove searches then shifts rows down, schedule
// walks up to task_count+1 slots. Tick skips the table. One item is worked
// on at a time; the next beat is taken as soon as the sequencer is idle,
// even while the previous result still waits in the output register.
// A stalled receiver holds the result register; a finished item then waits
// in the done state until the register frees up.
// Reset (rst_n low, synchronous) empties the table, selects idle, clears
// tick and idle counts and system_ready. Table rows need no clearing: only
// rows below task_count are used and those were written.
`default_nettype none
`include "priority_round_robin_task_scheduler_macros.svh"
module priority_round_robin_task_scheduler
  import prrs_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data,
  input  wire logic      cfg_wr_en,
  input  wire logic      cfg_wr_data
);

  localparam int IW = $clog2(SLOTS);
  localparam logic [IW-1:0] TC_MAX = IW'(SLOTS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_INS_CHK, S_INS_EV, S_SH_RD, S_SH_WR, S_INS_WR,
    S_FND_CHK, S_FND_EV, S_RM_RD, S_RM_WR, S_SCH_STEP, S_SCH_EV, S_DONE
  } state_t;

  state_t        state_r;
  in_item_t      item_r;
  logic [IW-1:0] tc_r, scan_r, ptr_r, j_r, start_r, p_r;
  logic [31:0]   tick_r, idle_sl_r, slices_r;
  logic [7:0]    sel_id_r;
  logic          sel_idle_r, sys_ready_r, sw_r, out_valid_r;
  logic [1:0]    status_r;
  logic [15:0]   fprio_r;
  out_item_t     out_r;

  logic          mem_we;
  logic [IW-1:0] mem_wa, mem_ra, p_nxt, scan_rm;
  entry_t        mem_wd, rd;
  logic          sw_now;

  prrs_mem #(.SLOTS(SLOTS)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_wa),
    .wdata (mem_wd),
    .raddr (mem_ra),
    .rdata (rd)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign sw_now    = (tc_r != '0) && sys_ready_r;
  // Advance cyclically past the idle slot.
  assign p_nxt     = (p_r >= tc_r) ? '0 : p_r + 1'b1;

  always_comb begin
    scan_rm = (ptr_r < scan_r) ? scan_r - 1'b1 : scan_r;
    if (scan_rm > tc_r - 1'b1) begin
      scan_rm = tc_r - 1'b1;
    end
  end

  // Table port drive: reads each visit, write-back on insert, modify or shift.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = ptr_r;
    mem_wd = rd;
    mem_ra = ptr_r;
    unique case (state_r)
      S_SH_RD:    mem_ra = j_r - 1'b1;
      S_SH_WR: begin
        mem_we = 1'b1;
        mem_wa = j_r;
      end
      S_INS_WR: begin
        mem_we = 1'b1;
        mem_wd = '{id: item_r.task_id, prio: item_r.priority_req, wake: '0, slices: '0};
      end
      S_FND_EV: begin
        if (rd.id == item_r.task_id && opcode_t'(item_r.opcode) == OP_DELAY) begin
          mem_we      = 1'b1;
          mem_wd.wake = tick_r + item_r.delay_ticks;
        end
      end
      S_RM_RD:    mem_ra = j_r + 1'b1;
      S_RM_WR: begin
        mem_we = 1'b1;
        mem_wa = j_r;
      end
      S_SCH_STEP: mem_ra = p_nxt;
      S_SCH_EV: begin
        mem_wa = p_r;
        if (rd.wake <= tick_r) begin
          mem_we        = 1'b1;
          mem_wd.wake   = '0;
          mem_wd.slices = rd.slices + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tc_r        <= '0;
      scan_r      <= '0;
      tick_r      <= '0;
      idle_sl_r   <= '0;
      sel_id_r    <= '0;
      sel_idle_r  <= 1'b1;
      sys_ready_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        sys_ready_r <= cfg_wr_data;
      end
      // The done state owns the valid flag while it loads the next beat.
      if (out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            item_r   <= in_data;
            status_r <= ST_OK;
            slices_r <= '0;
            fprio_r  <= '0;
            sw_r     <= 1'b0;
            ptr_r    <= '0;
            start_r  <= scan_r;
            p_r      <= scan_r;
            case (in_data.opcode)
              OP_INSERT: begin
                if (tc_r == TC_MAX) begin
                  status_r <= ST_FULL;
                  state_r  <= S_DONE;
                end else begin
                  state_r <= S_INS_CHK;
                end
              end
              OP_REMOVE, OP_DELAY, OP_FIND: state_r <= S_FND_CHK;
              OP_SCHEDULE: state_r <= S_SCH_STEP;
              OP_TICK: begin
                tick_r  <= tick_r + 1'b1;
                state_r <= S_DONE;
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_INS_CHK: begin
          j_r     <= tc_r;
          state_r <= (ptr_r == tc_r) ? S_SH_RD : S_INS_EV;
        end
        S_INS_EV: begin
          if (rd.prio <= item_r.priority_req) begin
            ptr_r   <= ptr_r + 1'b1;
            state_r <= S_INS_CHK;
          end else begin
            state_r <= S_SH_RD;
          end
        end
        S_SH_RD: state_r <= (j_r == ptr_r) ? S_INS_WR : S_SH_WR;
        S_SH_WR: begin
          j_r     <= j_r - 1'b1;
          state_r <= S_SH_RD;
        end
        S_INS_WR: begin
          tc_r <= tc_r + 1'b1;
          if (ptr_r <= scan_r) begin
            scan_r <= scan_r + 1'b1;
          end
          state_r <= S_DONE;
        end
        S_FND_CHK: begin
          if (ptr_r == tc_r) begin
            status_r <= ST_NOT_FOUND;
            state_r  <= S_DONE;
          end else begin
            state_r <= S_FND_EV;
          end
        end
        S_FND_EV: begin
          if (rd.id == item_r.task_id) begin
            j_r <= ptr_r;
            case (item_r.opcode)
              OP_REMOVE: state_r <= S_RM_RD;
              OP_DELAY:  state_r <= S_SCH_STEP;
              default: begin
                fprio_r <= rd.prio;
                state_r <= S_DONE;
              end
            endcase
          end else begin
            ptr_r   <= ptr_r + 1'b1;
            state_r <= S_FND_CHK;
          end
        end
        S_RM_RD: begin
          if (j_r == tc_r - 1'b1) begin
            tc_r    <= tc_r - 1'b1;
            scan_r  <= scan_rm;
            state_r <= S_DONE;
          end else begin
            state_r <= S_RM_WR;
          end
        end
        S_RM_WR: begin
          j_r     <= j_r + 1'b1;
          state_r <= S_RM_RD;
        end
        S_SCH_STEP: begin
          p_r <= p_nxt;
          if (p_nxt == start_r) begin
            // Back at the start: fall back to idle.
            scan_r     <= tc_r;
            sel_idle_r <= 1'b1;
            idle_sl_r  <= idle_sl_r + 1'b1;
            slices_r   <= idle_sl_r + 1'b1;
            sw_r       <= sw_now;
            state_r    <= S_DONE;
          end else if (p_nxt < tc_r) begin
            state_r <= S_SCH_EV;
          end
        end
        S_SCH_EV: begin
          if (rd.wake <= tick_r) begin
            scan_r     <= p_r;
            sel_id_r   <= rd.id;
            sel_idle_r <= 1'b0;
            slices_r   <= rd.slices + 1'b1;
            sw_r       <= sw_now;
            state_r    <= S_DONE;
          end else begin
            state_r <= S_SCH_STEP;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r          <= 1'b1;
            out_r.status         <= status_r;
            out_r.next_task      <= sel_idle_r ? 8'd0 : sel_id_r;
            out_r.next_is_idle   <= sel_idle_r;
            out_r.switch_request <= sw_r;
            out_r.next_slices    <= slices_r;
            out_r.found_priority <= fprio_r;
            state_r              <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `PRRS_ASSERT_IMP(a_tc_bound, 1'b1, tc_r <= TC_MAX, "task count beyond table")
  `PRRS_ASSERT_IMP(a_scan_bound, 1'b1, scan_r <= tc_r, "scan position beyond idle slot")
  `PRRS_ASSERT_IMP(a_wr_bound, mem_we, mem_wa <= tc_r, "table write beyond idle slot")
  `PRRS_ASSERT_NEXT(a_done_out, state_r == S_DONE && (!out_valid_r || out_ready),
                    out_valid_r && state_r == S_IDLE, "finished item not presented")

endmodule
`default_nettype wire
